[rtl/core/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int HEAP_AW      = $clog2(HEAP_BYTES);
    localparam int SIZE_W       = 13;
    localparam int HDR_W        = SIZE_W + 1;
    localparam int COUNT_W      = 10;
    localparam int FIELD_W      = 12;
    localparam int CFG_AW       = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_AW-1:0] REG_HEAP_SIZE = 3'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_FREE_RD,
        ST_FREE_WB,
        ST_DONE
    } ffha_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic set_fail;
        logic start_walk;
        logic rd_free;
        logic alloc_new;
        logic alloc_reuse;
        logic advance;
        logic free_wb;
        logic out_load;
    } ffha_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic op_free;
        logic off_low;
        logic fits;
        logic walk_more;
        logic hdr_used;
        logic hdr_zero;
        logic hdr_bigger;
        logic out_busy;
    } ffha_sts_t;

endpackage
`default_nettype wire

[rtl/core/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with its configuration register.
// A free request runs CHECK, FREE_RD, FREE_WB, DONE; an offset below a header goes CHECK to DONE.
// An allocate that exceeds the free bytes goes from CHECK to DONE; a walk reads each header in a
// WALK_RD and WALK_EVAL pair and ends in DONE, also when it runs past the heap end.
// The registered header store read spans WALK_RD and WALK_EVAL per header; a held result stalls
// in DONE, and the next request can be taken as early as the cycle in which the result appears.
// After aresetn the header store is cleared entry by entry with no request taken; counters reset
// to zero and heap_size to 4096.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] request_size, [23:12] block_offset
    input  wire logic [23:0]                     s_tdata,
    // [0] operation
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [11:0] payload_offset, [15:12] zero
    output logic [15:0]                          m_tdata,
    // [0] granted
    output logic                                 m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ffha_pkg::CFG_AW-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    ffha_pkg::ffha_cmd_t   cmd;
    ffha_pkg::ffha_sts_t   sts;
    ffha_pkg::ffha_state_t state;

    logic [ffha_pkg::SIZE_W-1:0]  heap_size_reg;
    logic [ffha_pkg::FIELD_W-1:0] m_offset;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ffha_pkg::CFG_AW-1:2]
                      == ffha_pkg::REG_HEAP_SIZE[ffha_pkg::CFG_AW-1:2]);
    assign prdata  = reg_sel ? 32'(heap_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_size_reg <= ffha_pkg::SIZE_W'(ffha_pkg::HEAP_BYTES);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            heap_size_reg <= pwdata[ffha_pkg::SIZE_W-1:0];
        end
    end

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    ffha_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .heap_size (heap_size_reg),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_offset  (m_offset)
    );

    assign m_tdata = 16'(m_offset);

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ffha_pkg::ST_CLEAR) |-> !s_tready)
        else $error("request taken during header store clearing");

    a_fail_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed request carries a nonzero offset");
`endif

endmodule
`default_nettype wire

[rtl/core/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/core/ffha_ctrl.sv]
// Controller state machine that sequences clearing, allocate walks and frees.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ffha_pkg::ffha_sts_t sts,
    output ffha_pkg::ffha_cmd_t      cmd,
    output ffha_pkg::ffha_state_t    state
);

    ffha_pkg::ffha_state_t state_reg;
    ffha_pkg::ffha_state_t state_next;

    assign state = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::ST_CLEAR: begin
                if (sts.clear_last) state_next = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = ffha_pkg::ST_CHECK;
            end
            ffha_pkg::ST_CHECK: begin
                if (sts.op_free) begin
                    state_next = sts.off_low ? ffha_pkg::ST_DONE : ffha_pkg::ST_FREE_RD;
                end else begin
                    state_next = sts.fits ? ffha_pkg::ST_WALK_RD : ffha_pkg::ST_DONE;
                end
            end
            ffha_pkg::ST_WALK_RD: begin
                state_next = sts.walk_more ? ffha_pkg::ST_WALK_EVAL : ffha_pkg::ST_DONE;
            end
            ffha_pkg::ST_WALK_EVAL: begin
                if (!sts.hdr_used && (sts.hdr_zero || sts.hdr_bigger)) begin
                    state_next = ffha_pkg::ST_DONE;
                end else if (sts.hdr_used && sts.hdr_zero) begin
                    state_next = ffha_pkg::ST_DONE;
                end else begin
                    state_next = ffha_pkg::ST_WALK_RD;
                end
            end
            ffha_pkg::ST_FREE_RD: state_next = ffha_pkg::ST_FREE_WB;
            ffha_pkg::ST_FREE_WB: state_next = ffha_pkg::ST_DONE;
            ffha_pkg::ST_DONE: begin
                if (!sts.out_busy) state_next = ffha_pkg::ST_IDLE;
            end
            default: state_next = ffha_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ffha_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            ffha_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ffha_pkg::ST_CHECK: begin
                if (sts.op_free) begin
                    cmd.set_fail = sts.off_low;
                end else begin
                    cmd.set_fail   = !sts.fits;
                    cmd.start_walk = sts.fits;
                end
            end
            ffha_pkg::ST_WALK_RD: cmd.set_fail = !sts.walk_more;
            ffha_pkg::ST_WALK_EVAL: begin
                if (!sts.hdr_used && sts.hdr_zero) begin
                    cmd.alloc_new = 1'b1;
                end else if (!sts.hdr_used && sts.hdr_bigger) begin
                    cmd.alloc_reuse = 1'b1;
                end else if (sts.hdr_used && sts.hdr_zero) begin
                    cmd.set_fail = 1'b1;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ffha_pkg::ST_FREE_RD: cmd.rd_free = 1'b1;
            ffha_pkg::ST_FREE_WB: begin
                cmd.rd_free = 1'b1;
                cmd.free_wb = 1'b1;
            end
            ffha_pkg::ST_DONE: cmd.out_load = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/ffha_dp.sv]
// Datapath with the header store, the usage counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ffha_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ffha_pkg::ffha_cmd_t                    cmd,
    output ffha_pkg::ffha_sts_t                         sts,
    input  wire logic [ffha_pkg::SIZE_W-1:0]            heap_size,
    input  wire logic                                   s_tuser,
    input  wire logic [2*ffha_pkg::FIELD_W-1:0]         s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic                                        m_tuser,
    output logic [ffha_pkg::FIELD_W-1:0]                m_offset
);

    localparam int SW = ffha_pkg::SIZE_W;
    localparam int AW = ffha_pkg::HEAP_AW;
    localparam int FW = ffha_pkg::FIELD_W;
    localparam int CW = ffha_pkg::COUNT_W;
    localparam int PW = SW + 1;
    localparam int VW = SW + 2;

    logic          op_reg;
    logic [FW-1:0] req_reg;
    logic [FW-1:0] off_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] clr_reg;
    logic [SW-1:0] bytes_reg;
    logic [CW-1:0] count_reg;
    logic          res_granted_reg;
    logic [FW-1:0] res_offset_reg;
    logic          m_valid_reg;
    logic          m_granted_reg;
    logic [FW-1:0] m_offset_reg;

    logic [SW-1:0]        need;
    logic [VW-1:0]        avail;
    logic [SW-1:0]        heap_limit;
    logic [AW-1:0]        hp;
    logic [ffha_pkg::HDR_W-1:0] rdata;
    logic [ffha_pkg::HDR_W-1:0] wdata;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [SW-1:0]        hdr_size;
    logic [SW-1:0]        add_amt;
    logic [SW-1:0]        sub_amt;
    logic [SW:0]          bytes_sum;
    logic [FW-1:0]        alloc_off;

    assign need     = SW'(req_reg) + SW'(ffha_pkg::HEADER_BYTES);
    assign avail    = VW'(heap_size) - VW'(bytes_reg)
                      - VW'(count_reg) * VW'(ffha_pkg::HEADER_BYTES);
    assign heap_limit = (heap_size > SW'(ffha_pkg::HEAP_BYTES))
                        ? SW'(ffha_pkg::HEAP_BYTES) : heap_size;
    assign hp       = AW'(off_reg - FW'(ffha_pkg::HEADER_BYTES));
    assign hdr_size = rdata[SW-1:0];
    assign alloc_off = pos_reg[FW-1:0] + FW'(ffha_pkg::HEADER_BYTES);

    assign sts.clear_last = (clr_reg == '1);
    assign sts.op_free    = (op_reg == ffha_pkg::OP_FREE);
    assign sts.off_low    = (off_reg < FW'(ffha_pkg::HEADER_BYTES));
    assign sts.fits       = !($signed(VW'(need)) > $signed(avail));
    assign sts.walk_more  = (VW'(heap_limit) > (VW'(pos_reg) + VW'(need)));
    assign sts.hdr_used   = rdata[SW];
    assign sts.hdr_zero   = (hdr_size == '0);
    assign sts.hdr_bigger = (hdr_size > need);
    assign sts.out_busy   = m_valid_reg && !m_tready;

    assign raddr = cmd.rd_free ? hp : pos_reg[AW-1:0];
    assign we    = cmd.clear_step || cmd.alloc_new || cmd.alloc_reuse || cmd.free_wb;

    always_comb begin
        waddr = pos_reg[AW-1:0];
        wdata = {1'b1, hdr_size};
        if (cmd.clear_step) begin
            waddr = clr_reg;
            wdata = '0;
        end else if (cmd.free_wb) begin
            waddr = hp;
            wdata = {1'b0, hdr_size};
        end else if (cmd.alloc_new) begin
            wdata = {1'b1, need};
        end
    end

    ffha_ram #(
        .WIDTH (ffha_pkg::HDR_W),
        .DEPTH (ffha_pkg::HEAP_BYTES)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign add_amt   = cmd.alloc_new ? SW'(req_reg)
                       : hdr_size - SW'(ffha_pkg::HEADER_BYTES);
    assign sub_amt   = (hdr_size >= SW'(ffha_pkg::HEADER_BYTES))
                       ? hdr_size - SW'(ffha_pkg::HEADER_BYTES) : '0;
    assign bytes_sum = (SW+1)'(bytes_reg) + (SW+1)'(add_amt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            bytes_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.alloc_new || cmd.alloc_reuse) begin
                bytes_reg <= bytes_sum[SW] ? '1 : bytes_sum[SW-1:0];
            end else if (cmd.free_wb) begin
                bytes_reg <= (sub_amt > bytes_reg) ? '0 : bytes_reg - sub_amt;
            end
            if (cmd.alloc_new && (count_reg != '1)) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.free_wb && (count_reg != '0)) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            req_reg <= s_tdata[FW-1:0];
            off_reg <= s_tdata[2*FW-1:FW];
        end
        if (cmd.start_walk) begin
            pos_reg <= '0;
        end else if (cmd.advance) begin
            pos_reg <= pos_reg + PW'(hdr_size);
        end
        if (cmd.set_fail) begin
            res_granted_reg <= 1'b0;
            res_offset_reg  <= '0;
        end else if (cmd.alloc_new || cmd.alloc_reuse) begin
            res_granted_reg <= 1'b1;
            res_offset_reg  <= alloc_off;
        end else if (cmd.free_wb) begin
            res_granted_reg <= 1'b1;
            res_offset_reg  <= '0;
        end
        if (cmd.out_load) begin
            m_granted_reg <= res_granted_reg;
            m_offset_reg  <= res_offset_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_granted_reg;
    assign m_offset = m_offset_reg;

endmodule
`default_nettype wire

[tb/first_fit_heap_allocator_tb.sv]
// Self-checking testbench for the first-fit heap allocator: stream requests, APB setup, checker.
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int BYTES_MAX      = (1 << SIZE_W) - 1;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_GAP        = 11;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] payload_offset;
    } heap_answer_t;

    class heap_ledger;
        logic [HDR_W-1:0] hdr_mem [HEAP_BYTES];
        int               bytes_used;
        int               hdr_count;
        int               heap_size;
        int               failures;
        heap_answer_t     pending_answers[$];

        function new();
            foreach (hdr_mem[i]) hdr_mem[i] = '0;
            bytes_used = 0;
            hdr_count  = 0;
            heap_size  = HEAP_BYTES;
            failures   = 0;
        endfunction

        function void set_heap_size(logic [SIZE_W-1:0] value);
            heap_size = value;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function void add_bytes(int amount);
            bytes_used = (bytes_used + amount > BYTES_MAX) ? BYTES_MAX : bytes_used + amount;
        endfunction

        function heap_answer_t carve_block(int req);
            heap_answer_t     ans;
            int               need;
            int               heap_limit;
            int               spare;
            int               pos;
            int               size;
            logic [HDR_W-1:0] hdr;
            ans.granted = 1'b0;
            ans.payload_offset = '0;
            need = req + HEADER_BYTES;
            heap_limit = (heap_size > HEAP_BYTES) ? HEAP_BYTES : heap_size;
            spare = heap_size - bytes_used - hdr_count * HEADER_BYTES;
            if (need > spare) return ans;
            pos = 0;
            while (heap_limit > pos + need) begin
                hdr = hdr_mem[pos];
                size = hdr[SIZE_W-1:0];
                if (!hdr[SIZE_W]) begin
                    if (size == 0 || size > need) begin
                        if (size == 0) begin
                            hdr_mem[pos] = {1'b1, SIZE_W'(need)};
                            if (hdr_count < COUNT_MAX) hdr_count++;
                            add_bytes(req);
                        end else begin
                            hdr_mem[pos] = {1'b1, SIZE_W'(size)};
                            add_bytes(size - HEADER_BYTES);
                        end
                        ans.granted = 1'b1;
                        ans.payload_offset = FIELD_W'(pos + HEADER_BYTES);
                        return ans;
                    end
                end else if (size == 0) begin
                    // A used header without a size breaks the chain.
                    return ans;
                end
                pos += size;
            end
            return ans;
        endfunction

        function heap_answer_t release_block(int off);
            heap_answer_t ans;
            int           hp;
            int           size;
            int           payload;
            ans.granted = 1'b0;
            ans.payload_offset = '0;
            if (off < HEADER_BYTES) return ans;
            hp = off - HEADER_BYTES;
            size = hdr_mem[hp][SIZE_W-1:0];
            hdr_mem[hp] = {1'b0, SIZE_W'(size)};
            if (hdr_count > 0) hdr_count--;
            payload = (size >= HEADER_BYTES) ? size - HEADER_BYTES : 0;
            bytes_used = (payload > bytes_used) ? 0 : bytes_used - payload;
            ans.granted = 1'b1;
            return ans;
        endfunction

        function heap_answer_t note_request(logic op, logic [FIELD_W-1:0] req,
                                            logic [FIELD_W-1:0] off);
            heap_answer_t ans;
            ans = (op == OP_ALLOC) ? carve_block(req) : release_block(off);
            pending_answers.push_back(ans);
            return ans;
        endfunction

        function void check_answer(logic granted, logic [FIELD_W-1:0] payload_offset);
            heap_answer_t want;
            if (pending_answers.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual granted %0b offset %0d",
                         $time, granted, payload_offset);
                return;
            end
            want = pending_answers.pop_front();
            if (granted !== want.granted) begin
                failures++;
                $display("%0t: granted mismatch, expected %0b, actual %0b",
                         $time, want.granted, granted);
            end
            if (payload_offset !== want.payload_offset) begin
                failures++;
                $display("%0t: payload_offset mismatch, expected %0d, actual %0d",
                         $time, want.payload_offset, payload_offset);
            end
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [CFG_AW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    heap_ledger         ledger;
    logic [FIELD_W-1:0] live_offsets[$];
    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int                 rx_wait   = 0;
    int                 idle_cycles = 0;

    first_fit_heap_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    always @(posedge aclk) begin : result_sink
        int gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                ledger.check_answer(m_tuser, m_tdata[FIELD_W-1:0]);
                if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
                gap = draw_gap(rx_steady);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    rx_wait <= gap;
                end
            end
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
            rx_wait <= 0;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [FIELD_W-1:0] req,
                                input logic [FIELD_W-1:0] off);
        int           gap;
        heap_answer_t ans;
        if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {off, req};
        do @(posedge aclk); while (!s_tready);
        ans = ledger.note_request(op, req, off);
        if (op == OP_ALLOC && ans.granted) begin
            live_offsets.push_back(ans.payload_offset);
        end
        if (op == OP_FREE) begin
            for (int k = live_offsets.size() - 1; k >= 0; k--) begin
                if (live_offsets[k] == off) live_offsets.delete(k);
            end
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ledger.pending() != 0);
    endtask

    task automatic write_heap_size(input logic [SIZE_W-1:0] value);
        logic [31:0] readback;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_HEAP_SIZE;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ledger.set_heap_size(value);
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[SIZE_W-1:0] !== value) begin
            ledger.failures++;
            $display("%0t: heap_size readback mismatch, expected %0d, actual %0d",
                     $time, value, readback[SIZE_W-1:0]);
        end
    endtask

    task automatic run_random(input int count, input int small_max);
        int                 pick;
        logic               op;
        logic [FIELD_W-1:0] req;
        logic [FIELD_W-1:0] off;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            req = FIELD_W'($urandom);
            off = FIELD_W'($urandom);
            if (pick < 10) begin
                // Stray frees: low offsets and arbitrary offsets.
                op = OP_FREE;
                if (pick < 3) off = FIELD_W'($urandom_range(0, HEADER_BYTES - 1));
            end else if (pick < 45 && live_offsets.size() > 0) begin
                op = OP_FREE;
                off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
            end else begin
                op = OP_ALLOC;
                pick = $urandom_range(0, 9);
                if (pick < 7) req = FIELD_W'($urandom_range(0, small_max));
                else if (pick < 9) req = FIELD_W'($urandom_range(64, 511));
            end
            if ($urandom_range(0, 39) == 0) wait_all_results();
            send_request(op, req, off);
        end
    endtask

    initial begin
        ledger = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_heap_size(SIZE_W'(HEAP_BYTES));

        send_request(OP_FREE, 12'h000, 12'hFFF);
        send_request(OP_FREE, 12'hFFF, 12'h000);
        send_request(OP_FREE, 12'h000, 12'd7);
        send_request(OP_ALLOC, 12'hFFF, 12'hFFF);
        send_request(OP_ALLOC, 12'd0, 12'h000);
        send_request(OP_ALLOC, 12'd16, 12'hAAA);
        send_request(OP_ALLOC, 12'd32, 12'h555);
        send_request(OP_FREE, 12'hAAA, 12'd16);
        send_request(OP_ALLOC, 12'd8, 12'h000);
        send_request(OP_FREE, 12'h555, 12'd16);
        send_request(OP_ALLOC, 12'd16, 12'h000);
        send_request(OP_FREE, 12'h000, 12'd8);
        send_request(OP_FREE, 12'h000, 12'd8);
        send_request(OP_ALLOC, 12'd0, 12'h000);
        send_request(OP_ALLOC, 12'd4000, 12'h000);
        send_request(OP_ALLOC, 12'd2047, 12'h000);
        send_request(OP_ALLOC, 12'd2047, 12'h000);
        send_request(OP_ALLOC, 12'h555, 12'hAAA);
        send_request(OP_FREE, 12'h000, 12'd80);
        send_request(OP_FREE, 12'h000, 12'd40);
        send_request(OP_FREE, 12'h000, 12'h800);
        send_request(OP_ALLOC, 12'hAAA, 12'h555);
        wait_all_results();

        run_random(180, 63);
        wait_all_results();

        write_heap_size(SIZE_W'(16));
        while (live_offsets.size() > 0) begin
            send_request(OP_FREE, FIELD_W'($urandom),
                         live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
        end
        run_random(30, 8);
        wait_all_results();

        write_heap_size(SIZE_W'(600));
        run_random(100, 63);
        wait_all_results();

        write_heap_size(SIZE_W'(HEAP_BYTES));
        run_random(100, 63);
        wait_all_results();
        repeat (20) @(posedge aclk);

        if (ledger.failures == 0 && ledger.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
